[hw/rtl/jetp_pkg.sv]
package jetp_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_ITER_DEF   = 128;
    localparam int IMG_WIDTH_DEF  = 1024;
    localparam int IMG_HEIGHT_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 28;

    // Fixed field widths.
    localparam int PIX_W   = 10;
    localparam int COLOR_W = 24;
    localparam int COUNT_W = 8;
    localparam int ZW      = 36;
    localparam int CREG_W  = 32;
    localparam int STEP_W  = 31;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    // Saturation limits of the signed working values.
    localparam logic signed [ZW-1:0] ZMAX = {1'b0, {(ZW-1){1'b1}}};
    localparam logic signed [ZW-1:0] ZMIN = {1'b1, {(ZW-1){1'b0}}};

    // Reset values of the configuration registers.
    localparam logic signed [CREG_W-1:0] CONST_REAL_RST = 32'sd214748365;
    localparam logic signed [CREG_W-1:0] CONST_IMAG_RST = 32'sd41875931;
    localparam logic [STEP_W-1:0]        PIXEL_STEP_RST = 31'd1342177;
    localparam logic [COLOR_W-1:0]       INSIDE_COL_RST = 24'h000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONST_REAL   = 2'd0,
        CFG_CONST_IMAG   = 2'd1,
        CFG_PIXEL_STEP   = 2'd2,
        CFG_INSIDE_COLOR = 2'd3
    } jetp_cfg_idx_t;

    typedef struct packed {
        logic signed [CREG_W-1:0] c_re;
        logic signed [CREG_W-1:0] c_im;
        logic [STEP_W-1:0]        step;
        logic [COLOR_W-1:0]       in_color;
    } jetp_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic init;
        logic mul;
        logic step;
        logic settle;
        logic finish;
    } jetp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic over;
        logic less;
        logic at_limit;
        logic out_free;
    } jetp_sts_t;

    // Escape-count palette.
    function automatic logic [COLOR_W-1:0] palette(input logic [15:0] n);
        logic [COLOR_W-1:0] col;
        if (n > 16'd100)      col = 24'hE0FFFF;
        else if (n > 16'd90)  col = 24'hAFEEEE;
        else if (n > 16'd70)  col = 24'hADD8E6;
        else if (n > 16'd50)  col = 24'h87CEEB;
        else if (n > 16'd30)  col = 24'h87CEFA;
        else if (n > 16'd10)  col = 24'h00BFFF;
        else if (n > 16'd5)   col = 24'h0000FF;
        else if (n > 16'd3)   col = 24'h0000CD;
        else if (n > 16'd1)   col = 24'h191970;
        else                  col = 24'h000000;
        return col;
    endfunction

endpackage

[hw/rtl/jetp_ctrl.sv]
module jetp_ctrl
    import jetp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  jetp_sts_t sts,
    output jetp_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_INIT = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_EVAL = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // Keep iterating while inside the circle and below the limit.
                if (!sts.over && sts.less && !sts.at_limit)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    cmd.settle = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hw/rtl/jetp_datapath.sv]
module jetp_datapath
    import jetp_pkg::*;
#(
    parameter int MAX_ITER   = MAX_ITER_DEF,
    parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = IMG_HEIGHT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PIX_W-1:0]     pixel_x,
    input  logic [PIX_W-1:0]     pixel_y,
    input  jetp_cfg_t            cfg,
    input  jetp_cmd_t            cmd,
    output jetp_sts_t            sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     out_x,
    output logic [PIX_W-1:0]     out_y,
    output logic [COLOR_W-1:0]   color,
    output logic [COUNT_W-1:0]   iteration_count
);

    localparam int CW     = $clog2(MAX_ITER + 1);
    localparam int HALF_W = IMG_WIDTH / 2;
    localparam int HALF_H = IMG_HEIGHT / 2;
    localparam int LOGW   = ($clog2(IMG_WIDTH) > $clog2(IMG_HEIGHT)) ?
                            $clog2(IMG_WIDTH) : $clog2(IMG_HEIGHT);
    localparam int DXW    = ((LOGW > PIX_W) ? LOGW : PIX_W) + 1;
    localparam int IPW    = DXW + CREG_W;
    // While iterating, |z| components stay within 2.0, so FRAC_BITS+3 bits hold them.
    localparam int MW     = FRAC_BITS + 3;
    localparam int PW     = 2 * MW;
    localparam int SUMW   = PW + 2;

    localparam logic signed [ZW-1:0] TWO     = ZW'(1) << (FRAC_BITS + 1);
    localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
    localparam logic [PW:0]          FOUR    = (PW + 1)'(1) << (2 * FRAC_BITS + 2);
    localparam logic [CW-1:0]        LIMIT   = CW'(MAX_ITER);

    function automatic logic signed [ZW-1:0] sat_init(input logic signed [IPW-1:0] v);
        logic signed [ZW-1:0] r;
        if (v > IPW'(ZMAX))      r = ZMAX;
        else if (v < IPW'(ZMIN)) r = ZMIN;
        else                     r = v[ZW-1:0];
        return r;
    endfunction

    function automatic logic signed [ZW-1:0] sat_upd(input logic signed [SUMW-1:0] v);
        logic signed [ZW-1:0] r;
        if (v > SUMW'(ZMAX))      r = ZMAX;
        else if (v < SUMW'(ZMIN)) r = ZMIN;
        else                      r = v[ZW-1:0];
        return r;
    endfunction

    // Control registers.
    logic m_valid_reg, m_valid_next;

    // Payload registers.
    logic [PIX_W-1:0]         px_reg, px_next;
    logic [PIX_W-1:0]         py_reg, py_next;
    logic signed [ZW-1:0]     zr_reg, zr_next;
    logic signed [ZW-1:0]     zi_reg, zi_next;
    logic [CW-1:0]            n_reg, n_next;
    logic signed [PW-1:0]     rr_reg, rr_next;
    logic signed [PW-1:0]     ii_reg, ii_next;
    logic signed [PW-1:0]     pr_reg, pr_next;
    logic                     over_reg, over_next;
    logic                     gt_reg, gt_next;
    logic [PIX_W-1:0]         ox_reg, ox_next;
    logic [PIX_W-1:0]         oy_reg, oy_next;
    logic [COLOR_W-1:0]       col_reg, col_next;
    logic [COUNT_W-1:0]       cnt_reg, cnt_next;

    logic signed [DXW-1:0]    dx, dy;
    logic signed [IPW-1:0]    x0_prod, y0_prod;
    logic signed [MW-1:0]     zr_n, zi_n;
    logic [PW:0]              sq_sum;
    logic signed [PW:0]       diff;
    logic signed [PW:0]       diff_sh;
    logic signed [PW-1:0]     pr_sh;
    logic signed [SUMW-1:0]   re_sum, im_sum;
    logic [CW+7:0]            n_ext;
    logic                     out_free;

    assign out_free = !m_valid_reg || m_tready;

    assign dx = $signed(DXW'(px_reg)) - $signed(DXW'(HALF_W));
    assign dy = $signed(DXW'(py_reg)) - $signed(DXW'(HALF_H));
    assign x0_prod = dx * $signed({1'b0, cfg.step});
    assign y0_prod = dy * $signed({1'b0, cfg.step});

    assign zr_n = zr_reg[MW-1:0];
    assign zi_n = zi_reg[MW-1:0];

    // Squares are never negative, so the sum is taken unsigned.
    assign sq_sum  = {1'b0, rr_reg} + {1'b0, ii_reg};
    assign diff    = (PW + 1)'(rr_reg) - (PW + 1)'(ii_reg);
    assign diff_sh = diff >>> FRAC_BITS;
    // Doubling before the shift is the same as shifting one place less.
    assign pr_sh   = pr_reg >>> (FRAC_BITS - 1);
    assign re_sum  = SUMW'(diff_sh) + SUMW'(cfg.c_re);
    assign im_sum  = SUMW'(pr_sh) + SUMW'(cfg.c_im);

    assign n_ext = {8'b0, n_reg};

    always_comb
    begin
        m_valid_next = m_valid_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        zr_next   = zr_reg;
        zi_next   = zi_reg;
        n_next    = n_reg;
        rr_next   = rr_reg;
        ii_next   = ii_reg;
        pr_next   = pr_reg;
        over_next = over_reg;
        gt_next   = gt_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        col_next  = col_reg;
        cnt_next  = cnt_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        if (cmd.capture)
        begin
            px_next = pixel_x;
            py_next = pixel_y;
        end
        if (cmd.init)
        begin
            zr_next = sat_init(x0_prod);
            zi_next = sat_init(y0_prod);
            n_next  = '0;
        end
        if (cmd.mul)
        begin
            rr_next   = zr_n * zr_n;
            ii_next   = zi_n * zi_n;
            pr_next   = zr_n * zi_n;
            over_next = (zr_reg > TWO) || (zr_reg < NEG_TWO) ||
                        (zi_reg > TWO) || (zi_reg < NEG_TWO);
        end
        if (cmd.step)
        begin
            zr_next = sat_upd(re_sum);
            zi_next = sat_upd(im_sum);
            n_next  = n_reg + CW'(1);
        end
        if (cmd.settle)
            gt_next = over_reg || (sq_sum > FOUR);
        if (cmd.finish)
        begin
            m_valid_next = 1'b1;
            ox_next  = px_reg;
            oy_next  = py_reg;
            col_next = gt_reg ? palette(16'(n_reg)) : cfg.in_color;
            cnt_next = (n_ext > (CW + 8)'(255)) ? 8'hFF : n_ext[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        n_reg    <= n_next;
        rr_reg   <= rr_next;
        ii_reg   <= ii_next;
        pr_reg   <= pr_next;
        over_reg <= over_next;
        gt_reg   <= gt_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        col_reg  <= col_next;
        cnt_reg  <= cnt_next;
    end

    assign sts.over     = over_reg;
    assign sts.less     = sq_sum < FOUR;
    assign sts.at_limit = (n_reg == LIMIT);
    assign sts.out_free = out_free;

    assign m_tvalid        = m_valid_reg;
    assign out_x           = ox_reg;
    assign out_y           = oy_reg;
    assign color           = col_reg;
    assign iteration_count = cnt_reg;

endmodule

[hw/rtl/julia_escape_time_pixel.sv]
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  pixel_x, pixel_y
// m_*       out        m_tvalid / m_tready  out_x, out_y, color, iteration_count
// cfg_*     in         cfg_we               const_real, const_imag, pixel_step, inside_color
//
// After a pixel is accepted, its result shows on m_tvalid once these steps are done: the
// start point is loaded, then each test of |z| takes a pass through the three parallel
// multipliers and a pass of compare, shift, add and saturate, and the output is loaded
// when the output register is free. The loop-carried z sets the pace.
// One pixel is in flight at a time; s_tready rises together with m_tvalid as the result is
// loaded, so a new pixel is accepted only after the last one's result is loaded.
// rst_n clears the controller and output valid asynchronously and reloads the cfg registers.
// A stalled result holds in the output register while the next pixel is accepted.
module julia_escape_time_pixel
    import jetp_pkg::*;
#(
    parameter int MAX_ITER   = MAX_ITER_DEF,
    parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = IMG_HEIGHT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, from bit 0: pixel_x [9:0], pixel_y [19:10], zero padding [23:20]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, from bit 0: out_x [9:0], out_y [19:10], color [43:20],
    // iteration_count [51:44], zero padding [55:52]
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CREG_W-1:0]     cfg_wdata
);

    // The configuration registers live here and feed the datapath as one group.
    jetp_cfg_t cfg_reg;
    jetp_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (jetp_cfg_idx_t'(cfg_index))
                CFG_CONST_REAL:   cfg_next.c_re     = $signed(cfg_wdata);
                CFG_CONST_IMAG:   cfg_next.c_im     = $signed(cfg_wdata);
                CFG_PIXEL_STEP:   cfg_next.step     = cfg_wdata[STEP_W-1:0];
                CFG_INSIDE_COLOR: cfg_next.in_color = cfg_wdata[COLOR_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.c_re     <= CONST_REAL_RST;
            cfg_reg.c_im     <= CONST_IMAG_RST;
            cfg_reg.step     <= PIXEL_STEP_RST;
            cfg_reg.in_color <= INSIDE_COL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    jetp_cmd_t cmd;
    jetp_sts_t sts;

    logic [PIX_W-1:0]   out_x;
    logic [PIX_W-1:0]   out_y;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] iteration_count;

    // The controller sequences one pixel: capture, start point, then
    // alternating multiply and evaluate cycles until escape or the limit.
    jetp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    jetp_datapath
    #(
        .MAX_ITER   (MAX_ITER),
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel_x         (s_tdata[PIX_W-1:0]),
        .pixel_y         (s_tdata[2*PIX_W-1:PIX_W]),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .sts             (sts),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_x           (out_x),
        .out_y           (out_y),
        .color           (color),
        .iteration_count (iteration_count)
    );

    // The result fields are packed from bit 0 upwards, padded to whole bytes.
    assign m_tdata = {4'b0, iteration_count, color, out_y, out_x};

endmodule
